[hw/rtl/p95s_pkg.sv]
package p95s_pkg;

  localparam int MAX_SAMPLES = 256;

  localparam int SAMPLE_W    = 63;
  localparam int COUNT_OUT_W = 9;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);

  localparam int IN_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_BITS    = SAMPLE_W + COUNT_OUT_W + 1;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // rank k = (RANK_NUM * n + RANK_BIAS) / RANK_DEN, clamped to n - 1
  localparam int RANK_NUM  = 95;
  localparam int RANK_BIAS = 149;
  localparam int RANK_DEN  = 100;

  // reciprocal scale chosen so the truncated product equals the exact quotient
  localparam int X_W      = $clog2(RANK_NUM * MAX_SAMPLES + RANK_BIAS + 1);
  localparam int RSHIFT   = X_W + 7;
  localparam int RECIP    = ((1 << RSHIFT) + RANK_DEN - 1) / RANK_DEN;
  localparam int RECIP_W  = $clog2(RECIP + 1);
  localparam int PROD_W   = X_W + RECIP_W;

endpackage

[hw/rtl/p95s_ram.sv]
module p95s_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/p95s_rank.sv]
module p95s_rank
  import p95s_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [CNT_W-1:0]  n,
  output logic              done,
  output logic [ADDR_W-1:0] k
);

  logic              v1;
  logic              v2;
  logic [X_W-1:0]    x;
  logic [PROD_W-1:0] prod;
  logic [CNT_W-1:0]  n1;
  logic [CNT_W-1:0]  n2;
  logic [CNT_W-1:0]  q;
  logic [CNT_W-1:0]  n_last;

  // exact quotient from the reciprocal product
  assign q      = CNT_W'(prod >> RSHIFT);
  assign n_last = n2 - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    x    <= X_W'(32'(n) * 32'(RANK_NUM) + 32'(RANK_BIAS));
    n1   <= n;
    prod <= PROD_W'(x) * PROD_W'(RECIP);
    n2   <= n1;
    k    <= (q > n_last) ? ADDR_W'(n_last) : ADDR_W'(q);
  end

endmodule

[hw/rtl/percentile_95_select_core.sv]
// insertion: a kept sample shifts m entries up (m = 0 to n-1) before it is written;
//   a dropped sample (store full) is not stored; one sram compare/move per cycle
// end of set: after the sample carrying tlast, the rank pipeline and an sram read run
//   before the result is loaded into the output register
// reset clears the sequencer, counts and output valid; the sorted store is not cleared
module percentile_95_select_core
  import p95s_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // sample
  input  logic                   s_tlast,   // last
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // rank_value, sample_count, overflowed
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SHIFT  = 3'd1;
  localparam logic [2:0] S_PLACE  = 3'd2;
  localparam logic [2:0] S_RSTART = 3'd3;
  localparam logic [2:0] S_RWAIT  = 3'd4;
  localparam logic [2:0] S_READ   = 3'd5;

  logic [2:0]          state;
  logic [SAMPLE_W-1:0] sample;
  logic                last_r;
  logic [CNT_W-1:0]    count;
  logic                ovf;
  logic [ADDR_W-1:0]   pos;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [SAMPLE_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;
  logic                greater;
  logic                rank_start;
  logic                rank_done;
  logic [ADDR_W-1:0]   k;
  logic                out_load;

  assign s_tready   = (state == S_IDLE);
  assign greater    = (ram_rdata > sample);
  assign rank_start = (state == S_RSTART);
  assign out_load   = (state == S_READ) && (!m_tvalid || m_tready);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos;
    ram_wdata = sample;
    ram_raddr = k;
    case (state)
      S_IDLE: begin
        ram_raddr = ADDR_W'(count - CNT_W'(1));
      end
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_wdata = greater ? ram_rdata : sample;
        // fetch the next lower entry while this one moves up
        ram_raddr = pos - ADDR_W'(2);
      end
      S_PLACE: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_raddr = k;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      ovf      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (count == CNT_W'(MAX_SAMPLES)) begin
              ovf   <= 1'b1;
              state <= s_tlast ? S_RSTART : S_IDLE;
            end else if (count == '0) begin
              state <= S_PLACE;
            end else begin
              state <= S_SHIFT;
            end
          end
        end
        S_SHIFT: begin
          if (greater) begin
            if (pos == ADDR_W'(1)) begin
              state <= S_PLACE;
            end
          end else begin
            count <= count + CNT_W'(1);
            state <= last_r ? S_RSTART : S_IDLE;
          end
        end
        S_PLACE: begin
          count <= count + CNT_W'(1);
          state <= last_r ? S_RSTART : S_IDLE;
        end
        S_RSTART: begin
          state <= S_RWAIT;
        end
        S_RWAIT: begin
          if (rank_done) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          if (out_load) begin
            count <= '0;
            ovf   <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      sample <= s_tdata[SAMPLE_W-1:0];
      last_r <= s_tlast;
      pos    <= ADDR_W'(count);
    end else if (state == S_SHIFT && greater) begin
      pos <= pos - ADDR_W'(1);
    end
    if (out_load) begin
      m_tdata <= {(OUT_TDATA_W - OUT_BITS)'(0), ovf, COUNT_OUT_W'(count), ram_rdata};
    end
  end

  p95s_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  p95s_rank u_rank (
    .clk   (clk),
    .rst   (rst),
    .start (rank_start),
    .n     (count),
    .done  (rank_done),
    .k     (k)
  );

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_SAMPLES))
    else $error("sample count beyond capacity");

  a_shift_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (pos != '0) && (CNT_W'(pos) <= count))
    else $error("shift position out of range");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_SHIFT) || (state == S_PLACE))
    else $error("store written outside insertion");

  a_rank_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (CNT_W'(k) < count))
    else $error("selected rank not below sample count");

  a_clear_after: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (count == '0) && !ovf && m_tvalid)
    else $error("set not cleared after result transfer");

endmodule
